@@ rtl/lruc_pkg.sv @@
// Shared constants, types and link structures of the key-value cache.
`timescale 1ns / 1ps
`default_nettype none
package lruc_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int CAP_W       = 5;
	localparam int AGE_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W       = (CAP_W > CNT_W) ? CAP_W : CNT_W;

	localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
	localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} lruc_op_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_UPD  = 3'b100
	} lruc_state_t;

	typedef struct packed {
		logic             look;
		logic             apply;
		logic             put;
		logic             hit;
		logic             insert;
		logic             evict_en;
		logic [AGE_W-1:0] evict_age;
		logic [AGE_W-1:0] hit_age;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} lruc_cmd_t;

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] value;
		logic [AGE_W-1:0] age;
		logic             taken;
	} lruc_link_t;

endpackage
`default_nettype wire

@@ rtl/lruc_in_if.sv @@
// Request channel: operation, key and value with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface lruc_in_if
	import lruc_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic                    operation;
	logic signed [KEY_W-1:0] key;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output operation, output key, output value, input ready);
	modport sink   (input valid, input operation, input key, input value, output ready);
endinterface
`default_nettype wire

@@ rtl/lruc_out_if.sv @@
// Response channel: found flag and read value with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface lruc_out_if
	import lruc_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic                    found;
	logic signed [VAL_W-1:0] read_value;

	modport source (output valid, output found, output read_value, input ready);
	modport sink   (input valid, input found, input read_value, output ready);
endinterface
`default_nettype wire

@@ rtl/lruc_cfg_if.sv @@
// Configuration write channel carrying the capacity register.
`timescale 1ns / 1ps
`default_nettype none
interface lruc_cfg_if
	import lruc_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] capacity;

	modport source (output valid, output capacity, input ready);
	modport sink   (input valid, input capacity, output ready);
endinterface
`default_nettype wire

@@ rtl/lruc_cell.sv @@
// One cache slot: key compare, age rank, and link to its neighbor.
`timescale 1ns / 1ps
`default_nettype none
module lruc_cell
	import lruc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire lruc_cmd_t  cmd,
	input  wire lruc_link_t link_in,
	output lruc_link_t      link_out
);

	logic             valid_q;
	logic [AGE_W-1:0] age_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;

	logic hit_s1;
	logic claim_s1;
	logic evict_s1;

	logic hit;
	logic evict_here;
	logic free_here;
	logic claim;

	always_comb begin
		hit        = valid_q && (key_q == cmd.key);
		evict_here = cmd.evict_en && valid_q && (age_q == cmd.evict_age);
		free_here  = !valid_q || evict_here;
		claim      = free_here && !link_in.taken;

		link_out.found = link_in.found | hit;
		link_out.value = link_in.value | (hit ? value_q : '0);
		link_out.age   = link_in.age | (hit ? age_q : '0);
		link_out.taken = link_in.taken | free_here;
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			hit_s1   <= hit;
			claim_s1 <= claim;
			evict_s1 <= evict_here;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (cmd.apply) begin
			if (cmd.hit) begin
				if (valid_q) begin
					if (hit_s1) begin
						age_q <= '0;
					end else if (age_q < cmd.hit_age) begin
						age_q <= age_q + 1'b1;
					end
				end
			end else if (cmd.insert) begin
				if (claim_s1) begin
					valid_q <= 1'b1;
					age_q   <= '0;
				end else if (evict_s1) begin
					valid_q <= 1'b0;
				end else if (valid_q) begin
					age_q <= age_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			if (cmd.hit && hit_s1 && cmd.put) begin
				value_q <= cmd.value;
			end else if (!cmd.hit && cmd.insert && claim_s1) begin
				key_q   <= cmd.key;
				value_q <= cmd.value;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/lru_key_value_cache_core.sv @@
// Top level of the fully associative key-value cache with LRU replacement.
//
// channel  dir  handshake      payload
// req      in   valid/ready    operation, key, value
// rsp      out  valid/ready    found, read_value
// cfg      in   valid/ready    capacity
//
// Each request passes a lookup state, which compares the key in every cell and
// ripples hit, value, age and free-slot claim along the cell chain, then an
// update state, which applies the new ages, value and slot state in all cells.
// After reset all slots are invalid; capacity resets to sixteen.
// A waiting response holds the update cycle until rsp is taken.
`timescale 1ns / 1ps
`default_nettype none
module lru_key_value_cache_core
	import lruc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	lruc_in_if.sink   req,
	lruc_out_if.source rsp,
	lruc_cfg_if.sink  cfg
);

	lruc_state_t state_q;

	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] live_count_q;

	logic             req_op_q;
	logic [KEY_W-1:0] req_key_q;
	logic [VAL_W-1:0] req_value_q;

	logic             found_s1;
	logic [VAL_W-1:0] value_s1;
	logic [AGE_W-1:0] age_s1;
	logic             evict_s1;

	logic             out_valid_q;
	logic             out_found_q;
	logic [VAL_W-1:0] out_value_q;

	logic             upd_go;
	logic             in_fire;
	logic [CMP_W-1:0] cap_ext;
	logic [CMP_W-1:0] cap_eff;
	logic [CMP_W-1:0] lc_ext;
	logic             do_evict;
	logic             insert;

	lruc_cmd_t  cmd;
	lruc_link_t link [MAX_ENTRIES+1];

	always_comb begin
		upd_go    = !out_valid_q || rsp.ready;
		req.ready = (state_q == ST_IDLE) || ((state_q == ST_UPD) && upd_go);
		in_fire   = req.valid && req.ready;
		cfg.ready = 1'b1;

		cap_ext  = CMP_W'(capacity_q);
		cap_eff  = (cap_ext > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_ext;
		lc_ext   = CMP_W'(live_count_q);
		do_evict = (lc_ext >= cap_eff) && (live_count_q != '0);
		insert   = (req_op_q == OP_PUT) && !found_s1 && (capacity_q != '0);

		cmd.look      = (state_q == ST_LOOK);
		cmd.apply     = (state_q == ST_UPD) && upd_go;
		cmd.put       = (req_op_q == OP_PUT);
		cmd.hit       = found_s1;
		cmd.insert    = insert;
		cmd.evict_en  = do_evict;
		cmd.evict_age = AGE_W'(live_count_q - 1'b1);
		cmd.hit_age   = age_s1;
		cmd.key       = req_key_q;
		cmd.value     = req_value_q;
	end

	assign link[0] = '0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		lruc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.link_in  (link[i]),
			.link_out (link[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_go) state_q <= in_fire ? ST_LOOK : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			capacity_q <= cfg.capacity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_count_q <= '0;
		end else if (cmd.apply && insert && !evict_s1) begin
			live_count_q <= live_count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_op_q    <= req.operation;
			req_key_q   <= req.key;
			req_value_q <= req.value;
		end
		if (cmd.look) begin
			found_s1 <= link[MAX_ENTRIES].found;
			value_s1 <= link[MAX_ENTRIES].value;
			age_s1   <= link[MAX_ENTRIES].age;
			evict_s1 <= do_evict;
		end
		if (cmd.apply) begin
			out_found_q <= found_s1;
			if (req_op_q == OP_PUT) begin
				out_value_q <= '0;
			end else begin
				out_value_q <= found_s1 ? value_s1 : MISS_VALUE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.apply) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.found      = out_found_q;
	assign rsp.read_value = out_value_q;

endmodule
`default_nettype wire
